// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clk_i and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ITG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/itg_pkg.sv =====
// ----------------------------------------------------------------------------
// itg_pkg
// shared types, constants and helpers of the tile grid generator
// ----------------------------------------------------------------------------
package itg_pkg;

  localparam int DimBits  = 16;
  localparam int CntBits  = 32;
  localparam int DivDw    = DimBits;
  localparam int DivRw    = 32;
  localparam int IterBits = 6;
  localparam int CfgIdxBits = 3;

  // the pixel budget 8000000 is 15625 shifted left by 9; the odd factor is
  // divided out by a reciprocal multiply that is exact over the given range
  localparam logic [13:0] BudgetOdd        = 14'd15625;
  localparam logic [23:0] RecipNarrow      = 24'd8796094;    // operand below 2^23
  localparam int          RecipNarrowShift = 37;
  localparam logic [30:0] RecipWide        = 31'd1125899907; // operand below 2^30
  localparam int          RecipWideShift   = 44;

  localparam logic [IterBits-1:0] DivItersDim  = 6'd16;

  localparam logic [CfgIdxBits-1:0] CfgAutoSplit   = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgImageWidth  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgImageHeight = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgTileWidth   = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgBandHeight  = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgFrameCount  = 3'd5;

  typedef struct packed {
    logic restart;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic [DimBits-1:0] tile_x;
    logic [DimBits-1:0] tile_y;
    logic [DimBits-1:0] tile_w;
    logic [DimBits-1:0] tile_h;
    logic [CntBits-1:0] tile_number;
    logic               last_tile;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } res_wr_t;

  typedef struct packed {
    logic                start;
    logic [DivDw-1:0]    dividend;
    logic [DivRw-1:0]    divisor;
    logic [IterBits-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivDw-1:0] quot;
    logic [DivRw-1:0] rem;
  } div_rsp_t;

  // a dimension that reads zero counts as one
  function automatic logic [DimBits-1:0] at_least_one(input logic [DimBits-1:0] v);
    return (v == '0) ? {{(DimBits-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

// ===== rtl/itg_front.sv =====
// ----------------------------------------------------------------------------
// itg_front
// request queue: takes items from the push side and hands them to the sequencer
// ----------------------------------------------------------------------------
module itg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              restart_i,
  output itg_pkg::cmd_head_t head_o,
  input  logic              pop_i
);
  import itg_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full    = (count_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = pop_i && (count_q != 2'd0);

  assign head_o.valid       = (count_q != 2'd0);
  assign head_o.cmd         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q].restart <= restart_i;
    end
  end

endmodule

// ===== rtl/itg_div.sv =====
// ----------------------------------------------------------------------------
// itg_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module itg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itg_pkg::div_req_t req_i,
  output itg_pkg::div_rsp_t rsp_o
);
  import itg_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [IterBits-1:0] cnt_q, cnt_d;
  logic [DivDw-1:0]    d_q;
  logic [DivRw-1:0]    r_q;
  logic [DivRw-1:0]    dvs_q;
  logic [DivRw:0]      trial;
  logic [DivRw:0]      diff;
  logic                ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {r_q, d_q[DivDw-1]};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = d_q;
  assign rsp_o.rem  = r_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
    end else if (busy_q) begin
      cnt_d = cnt_q - {{(IterBits-1){1'b0}}, 1'b1};
      if (cnt_q == {{(IterBits-1){1'b0}}, 1'b1}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      d_q   <= req_i.dividend;
      r_q   <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      d_q <= {d_q[DivDw-2:0], ge};
      r_q <= ge ? diff[DivRw-1:0] : trial[DivRw-1:0];
    end
  end

endmodule

// ===== rtl/itg_core.sv =====
// ----------------------------------------------------------------------------
// itg_core
// tile sequencer: band setup through the shared divider, then tile emission
// ----------------------------------------------------------------------------
module itg_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itg_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [itg_pkg::DimBits-1:0]    cfg_data_i,
  input  itg_pkg::cmd_head_t             head_i,
  output logic                           cmd_pop_o,
  output itg_pkg::div_req_t              div_req_o,
  input  itg_pkg::div_rsp_t              div_rsp_i,
  input  logic                           out_full_i,
  output itg_pkg::res_wr_t               res_wr_o
);
  import itg_pkg::*;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StProd   = 4'd1;
  localparam logic [3:0] StCheck  = 4'd2;
  localparam logic [3:0] StFxWait = 4'd3;
  localparam logic [3:0] StQuot   = 4'd4;
  localparam logic [3:0] StRem    = 4'd5;
  localparam logic [3:0] StScale  = 4'd6;
  localparam logic [3:0] StCeil   = 4'd7;
  localparam logic [3:0] StCount  = 4'd8;
  localparam logic [3:0] StWnGo   = 4'd9;
  localparam logic [3:0] StWnWait = 4'd10;
  localparam logic [3:0] StEmit   = 4'd11;

  logic [3:0] st_q, st_d;

  // configuration registers
  logic               auto_q, auto_d;
  logic [DimBits-1:0] w_raw_q, w_raw_d;
  logic [DimBits-1:0] h_raw_q, h_raw_d;
  logic [DimBits-1:0] tw_raw_q, tw_raw_d;
  logic [DimBits-1:0] bh_raw_q, bh_raw_d;
  logic [DimBits-1:0] f_raw_q, f_raw_d;

  // walk state
  logic [DimBits-1:0] bi_q, bi_d;
  logic [CntBits-1:0] col_q, col_d;
  logic [DimBits-1:0] x_q, x_d;
  logic [CntBits-1:0] pieces_q, pieces_d;
  logic [DimBits-1:0] base_q, base_d;
  logic [DimBits-1:0] wide_q, wide_d;
  logic [DimBits-1:0] rows_q, rows_d;
  logic [CntBits-1:0] ctr_q, ctr_d;
  logic               need_q, need_d;

  // setup scratch
  logic [2*DimBits-1:0] p0_q, p0_d;
  logic [2*DimBits-1:0] a_q, a_d;
  logic [9:0]           qa_q, qa_d;
  logic [22:0]          ra_q, ra_d;
  logic [38:0]          m1_q, m1_d;
  logic [25:0]          m2_q, m2_d;
  logic [15:0]          q2_q, q2_d;
  logic [DivRw-1:0]     n_q, n_d;

  logic [DimBits-1:0]   w_eff, h_eff, tw_eff, bh_eff, f_eff;
  logic [2*DimBits:0]   p1;
  logic [CntBits-1:0]   col_inc;
  logic [22:0]          qa_x;
  logic [46:0]          qa_prod;
  logic [23:0]          qa_back;
  logic [23:0]          ra_hi;
  logic [29:0]          nb_x;
  logic [60:0]          nb_prod;
  logic [29:0]          nb_back;
  logic                 nb_frac;
  logic [DivRw-1:0]     n_sum;
  logic                 last_col, last_band, last;
  logic [DimBits-1:0]   width;

  assign w_eff  = at_least_one(w_raw_q);
  assign h_eff  = at_least_one(h_raw_q);
  assign tw_eff = at_least_one(tw_raw_q);
  assign bh_eff = at_least_one(bh_raw_q);
  assign f_eff  = at_least_one(f_raw_q);

  assign p1        = {1'b0, p0_q} + (2*DimBits+1)'(bh_eff);
  assign col_inc   = col_q + {{(CntBits-1){1'b0}}, 1'b1};
  assign last_col  = (col_inc >= pieces_q);
  // band index + 1 reaches the band count exactly when its end row covers the image
  assign last_band = (p1 >= (2*DimBits+1)'(h_eff));
  assign last      = last_col && last_band;

  // width * frames split into budget quotient and remainder
  assign qa_x    = a_q[31:9];
  assign qa_prod = 47'(qa_x) * 47'(RecipNarrow);
  assign qa_back = 24'(qa_q) * 24'(BudgetOdd);
  assign ra_hi   = {1'b0, qa_x} - qa_back;

  // ceiling of the remainder share: quotient plus one when anything is left
  assign nb_x    = m1_q[38:9];
  assign nb_prod = 61'(nb_x) * 61'(RecipWide);
  assign nb_back = 30'(q2_q) * 30'(BudgetOdd);
  assign nb_frac = (nb_x != nb_back) || (m1_q[8:0] != '0);
  assign n_sum   = DivRw'(m2_q) + DivRw'(q2_q) + DivRw'(nb_frac);

  always_comb begin
    if (!auto_q) begin
      width = (last_col && (wide_q != '0)) ? wide_q : base_q;
    end else begin
      width = base_q + ((col_q < CntBits'(wide_q)) ? {{(DimBits-1){1'b0}}, 1'b1} : '0);
    end
  end

  always_comb begin
    st_d     = st_q;
    auto_d   = auto_q;
    w_raw_d  = w_raw_q;
    h_raw_d  = h_raw_q;
    tw_raw_d = tw_raw_q;
    bh_raw_d = bh_raw_q;
    f_raw_d  = f_raw_q;
    bi_d     = bi_q;
    col_d    = col_q;
    x_d      = x_q;
    pieces_d = pieces_q;
    base_d   = base_q;
    wide_d   = wide_q;
    rows_d   = rows_q;
    ctr_d    = ctr_q;
    need_d   = need_q;
    p0_d     = p0_q;
    a_d      = a_q;
    qa_d     = qa_q;
    ra_d     = ra_q;
    m1_d     = m1_q;
    m2_d     = m2_q;
    q2_d     = q2_q;
    n_d      = n_q;

    cmd_pop_o          = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = '0;
    div_req_o.divisor  = '0;
    div_req_o.iters    = '0;
    res_wr_o.push            = 1'b0;
    res_wr_o.res.tile_x      = x_q;
    res_wr_o.res.tile_y      = p0_q[DimBits-1:0];
    res_wr_o.res.tile_w      = width;
    res_wr_o.res.tile_h      = rows_q;
    res_wr_o.res.tile_number = ctr_q;
    res_wr_o.res.last_tile   = last;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgAutoSplit:   auto_d   = cfg_data_i[0];
        CfgImageWidth:  w_raw_d  = cfg_data_i;
        CfgImageHeight: h_raw_d  = cfg_data_i;
        CfgTileWidth:   tw_raw_d = cfg_data_i;
        CfgBandHeight:  bh_raw_d = cfg_data_i;
        CfgFrameCount:  f_raw_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (st_q)
      StIdle: begin
        if (head_i.valid && !out_full_i) begin
          cmd_pop_o = 1'b1;
          need_d    = head_i.cmd.restart || (pieces_q == '0);
          if (head_i.cmd.restart) begin
            bi_d     = '0;
            col_d    = '0;
            x_d      = '0;
            pieces_d = '0;
            ctr_d    = '0;
          end
          st_d = StProd;
        end
      end
      StProd: begin
        p0_d = (2*DimBits)'(bi_q) * (2*DimBits)'(bh_eff);
        st_d = need_q ? StCheck : StEmit;
      end
      StCheck: begin
        if (p0_q >= (2*DimBits)'(h_eff)) begin
          // band fell below the image bottom: back to the first tile
          bi_d     = '0;
          col_d    = '0;
          x_d      = '0;
          pieces_d = '0;
          ctr_d    = '0;
          st_d     = StProd;
        end else begin
          rows_d = (p1 > (2*DimBits+1)'(h_eff)) ?
                   DimBits'((2*DimBits)'(h_eff) - p0_q) : bh_eff;
          a_d    = (2*DimBits)'(w_eff) * (2*DimBits)'(f_eff);
          if (!auto_q) begin
            div_req_o.start    = 1'b1;
            div_req_o.dividend = w_eff;
            div_req_o.divisor  = DivRw'(tw_eff);
            div_req_o.iters    = DivItersDim;
            st_d = StFxWait;
          end else begin
            st_d = StQuot;
          end
        end
      end
      StFxWait: begin
        if (div_rsp_i.done) begin
          pieces_d = CntBits'(div_rsp_i.quot[DimBits-1:0]) +
                     ((div_rsp_i.rem != '0) ? {{(CntBits-1){1'b0}}, 1'b1} : '0);
          base_d   = tw_eff;
          wide_d   = div_rsp_i.rem[DimBits-1:0];
          st_d     = StEmit;
        end
      end
      StQuot: begin
        qa_d = qa_prod[RecipNarrowShift+9:RecipNarrowShift];
        st_d = StRem;
      end
      StRem: begin
        ra_d = {ra_hi[13:0], a_q[8:0]};
        m2_d = 26'(qa_q) * 26'(rows_q);
        st_d = StScale;
      end
      StScale: begin
        m1_d = 39'(ra_q) * 39'(rows_q);
        st_d = StCeil;
      end
      StCeil: begin
        q2_d = nb_prod[RecipWideShift+15:RecipWideShift];
        st_d = StCount;
      end
      StCount: begin
        n_d  = (n_sum == '0) ? {{(DivRw-1){1'b0}}, 1'b1} : n_sum;
        st_d = StWnGo;
      end
      StWnGo: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = w_eff;
        div_req_o.divisor  = n_q;
        div_req_o.iters    = DivItersDim;
        st_d = StWnWait;
      end
      StWnWait: begin
        if (div_rsp_i.done) begin
          pieces_d = n_q;
          base_d   = div_rsp_i.quot[DimBits-1:0];
          wide_d   = div_rsp_i.rem[DimBits-1:0];
          st_d     = StEmit;
        end
      end
      StEmit: begin
        res_wr_o.push = 1'b1;
        if (last) begin
          bi_d     = '0;
          col_d    = '0;
          x_d      = '0;
          pieces_d = '0;
          ctr_d    = '0;
        end else begin
          if (ctr_q != '1) begin
            ctr_d = ctr_q + {{(CntBits-1){1'b0}}, 1'b1};
          end
          if (last_col) begin
            col_d    = '0;
            x_d      = '0;
            pieces_d = '0;
            bi_d     = bi_q + {{(DimBits-1){1'b0}}, 1'b1};
          end else begin
            col_d = col_inc;
            x_d   = x_q + width;
          end
        end
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      auto_q   <= 1'b0;
      w_raw_q  <= 16'd64;
      h_raw_q  <= 16'd64;
      tw_raw_q <= 16'd64;
      bh_raw_q <= 16'd64;
      f_raw_q  <= 16'd1;
      bi_q     <= '0;
      col_q    <= '0;
      x_q      <= '0;
      pieces_q <= '0;
      base_q   <= '0;
      wide_q   <= '0;
      rows_q   <= '0;
      ctr_q    <= '0;
      need_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      auto_q   <= auto_d;
      w_raw_q  <= w_raw_d;
      h_raw_q  <= h_raw_d;
      tw_raw_q <= tw_raw_d;
      bh_raw_q <= bh_raw_d;
      f_raw_q  <= f_raw_d;
      bi_q     <= bi_d;
      col_q    <= col_d;
      x_q      <= x_d;
      pieces_q <= pieces_d;
      base_q   <= base_d;
      wide_q   <= wide_d;
      rows_q   <= rows_d;
      ctr_q    <= ctr_d;
      need_q   <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    a_q  <= a_d;
    qa_q <= qa_d;
    ra_q <= ra_d;
    m1_q <= m1_d;
    m2_q <= m2_d;
    q2_q <= q2_d;
    n_q  <= n_d;
  end

endmodule

// ===== rtl/itg_outq.sv =====
// ----------------------------------------------------------------------------
// itg_outq
// result queue: holds finished tiles until the pop side takes them
// ----------------------------------------------------------------------------
module itg_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itg_pkg::res_wr_t wr_i,
  output logic             full_o,
  output logic             empty,
  input  logic             pop,
  output itg_pkg::res_t    head_o
);
  import itg_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty   = (count_q == 2'd0);
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop && !empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.res;
    end
  end

endmodule

// ===== rtl/image_tile_grid_generator.sv =====
// Each pushed request yields one crop rectangle; tiles run band by band, left
// to right. A request that continues the current band passes through the idle,
// product and emit states of the sequencer. The first tile of a band also sets
// the band up: in fixed-width mode by a 16-step bit-serial division of the width
// by the tile width; in auto-split mode the piece count comes from reciprocal
// multiplies in the quotient, remainder, scale, ceiling and count states, then
// the same serial division of the width by the piece count. A walk that has
// to wrap back to the top of the image goes through the product and check
// steps once more. The sequencer waits while the result queue is full. Two-entry
// queues on both sides let requests and results wait while the sequencer works.
// ----------------------------------------------------------------------------
// image_tile_grid_generator
// top level: request queue, tile sequencer, shared divider, result queue
// ----------------------------------------------------------------------------
module image_tile_grid_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [itg_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [itg_pkg::DimBits-1:0]    cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           restart_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [itg_pkg::DimBits-1:0]    tile_x_o,
  output logic [itg_pkg::DimBits-1:0]    tile_y_o,
  output logic [itg_pkg::DimBits-1:0]    tile_w_o,
  output logic [itg_pkg::DimBits-1:0]    tile_h_o,
  output logic [itg_pkg::CntBits-1:0]    tile_number_o,
  output logic                           last_tile_o
);
  import itg_pkg::*;

  `include "assert_macros.svh"

  cmd_head_t head;
  logic      cmd_pop;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  res_wr_t   res_wr;
  logic      outq_full;
  res_t      res_head;

  itg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .restart_i (restart_i),
    .head_o    (head),
    .pop_i     (cmd_pop)
  );

  itg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  itg_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .head_i     (head),
    .cmd_pop_o  (cmd_pop),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .out_full_i (outq_full),
    .res_wr_o   (res_wr)
  );

  itg_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_wr),
    .full_o (outq_full),
    .empty  (empty),
    .pop    (pop),
    .head_o (res_head)
  );

  assign tile_x_o      = res_head.tile_x;
  assign tile_y_o      = res_head.tile_y;
  assign tile_w_o      = res_head.tile_w;
  assign tile_h_o      = res_head.tile_h;
  assign tile_number_o = res_head.tile_number;
  assign last_tile_o   = res_head.last_tile;

  // the sequencer only starts an item when the result queue has room
  `ITG_ASSERT_IMP(a_res_no_overflow, res_wr.push, !outq_full, "result pushed into full queue")
  // no new division while one is still running
  `ITG_ASSERT_IMP(a_div_no_restart, div_req.start, !div_rsp.busy, "divider restarted while busy")
  // every waiting tile covers at least one row
  `ITG_ASSERT_IMP(a_tile_h_nonzero, !empty, tile_h_o != '0, "tile with zero height")
  // a popped command is followed by its product step, never by another pop
  `ITG_ASSERT_NXT(a_single_item, cmd_pop, !cmd_pop, "two requests taken back to back")

endmodule

// ===== dv/image_tile_grid_generator_tb.sv =====
// ----------------------------------------------------------------------------
// image_tile_grid_generator_tb
// Self-checking bench for the tile grid generator. Requests go in through the
// push/full side and tiles come back through the empty/pop side. Every accepted
// request is run through a local model of the band/column walk, and each tile
// is compared field by field against the oldest predicted tile. Covers fixed
// and auto split layouts, zero and full-scale registers, over-split bands, band
// rewrites between requests, restarts, random idling and a long output stall.
// ----------------------------------------------------------------------------
module image_tile_grid_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itg_pkg::*;

  localparam logic [63:0] PIXEL_BUDGET = 64'd8000000;
  localparam int          WATCHDOG_CYCLES = 20000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          TAIL_CYCLES = 120;
  localparam int          RANDOM_PHASES = 24;
  localparam int          ITEMS_PER_PHASE = 50;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = CfgAutoSplit;
  logic [DimBits-1:0]    cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic                  restart_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [DimBits-1:0]    tile_x_o;
  logic [DimBits-1:0]    tile_y_o;
  logic [DimBits-1:0]    tile_w_o;
  logic [DimBits-1:0]    tile_h_o;
  logic [CntBits-1:0]    tile_number_o;
  logic                  last_tile_o;

  image_tile_grid_generator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .restart_i     (restart_i),
    .empty         (empty),
    .pop           (pop),
    .tile_x_o      (tile_x_o),
    .tile_y_o      (tile_y_o),
    .tile_w_o      (tile_w_o),
    .tile_h_o      (tile_h_o),
    .tile_number_o (tile_number_o),
    .last_tile_o   (last_tile_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the registers, updated as they are written
  logic        auto_split_q = 1'b0;
  logic [15:0] img_w_q = 16'd64;
  logic [15:0] img_h_q = 16'd64;
  logic [15:0] tile_w_q = 16'd64;
  logic [15:0] band_h_q = 16'd64;
  logic [15:0] frames_q = 16'd1;

  // walk state of the tile model
  logic [15:0] band_idx = '0;
  logic [31:0] col_idx = '0;
  logic [15:0] x_pos = '0;
  logic [31:0] piece_cnt = '0;
  logic [15:0] piece_w = '0;
  logic [15:0] wide_cnt = '0;
  logic [15:0] band_rows = '0;
  logic [31:0] tile_cnt = '0;

  res_t tiles_due[$];
  res_t tile_want;

  int unsigned errors = 0;
  int unsigned requests_sent = 0;
  int unsigned tiles_checked = 0;
  int unsigned configs_applied = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic        idle_on = 1'b1;
  logic        hold_off_go = 1'b0;

  function automatic logic [63:0] one_if_zero(input logic [15:0] v);
    return (v == 16'd0) ? 64'd1 : {48'd0, v};
  endfunction

  function automatic logic [63:0] band_total();
    logic [63:0] h, bh;
    h  = one_if_zero(img_h_q);
    bh = one_if_zero(band_h_q);
    return (h + bh - 64'd1) / bh;
  endfunction

  function automatic void rewind_walk();
    band_idx  = '0;
    col_idx   = '0;
    x_pos     = '0;
    piece_cnt = '0;
    tile_cnt  = '0;
  endfunction

  // latch piece count and widths for the band that is about to start
  function automatic void open_band();
    logic [63:0] w, h, bh, f, tw, nb, prod, n, tmp, rows;
    w  = one_if_zero(img_w_q);
    h  = one_if_zero(img_h_q);
    bh = one_if_zero(band_h_q);
    f  = one_if_zero(frames_q);
    if ({48'd0, band_idx} * bh >= h) rewind_walk();
    nb = band_total();
    band_rows = bh[15:0];
    if ({48'd0, band_idx} + 64'd1 == nb && (h % bh) != 64'd0) begin
      tmp = h % bh;
      band_rows = tmp[15:0];
    end
    if (!auto_split_q) begin
      tw = one_if_zero(tile_w_q);
      tmp = (w + tw - 64'd1) / tw;
      piece_cnt = tmp[31:0];
      piece_w = tw[15:0];
      tmp = w % tw;
      wide_cnt = tmp[15:0];
    end else begin
      rows = {48'd0, band_rows};
      prod = w * f;
      n = (prod / PIXEL_BUDGET) * rows
        + ((prod % PIXEL_BUDGET) * rows + PIXEL_BUDGET - 64'd1) / PIXEL_BUDGET;
      if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
      if (n == 64'd0) n = 64'd1;
      piece_cnt = n[31:0];
      tmp = w / n;
      piece_w = tmp[15:0];
      tmp = w % n;
      wide_cnt = tmp[15:0];
    end
  endfunction

  function automatic res_t next_tile(input logic restart);
    res_t        t;
    logic [63:0] bh, ypos;
    logic [31:0] width;
    logic        last_col, last_band;
    bh = one_if_zero(band_h_q);
    if (restart) rewind_walk();
    if (piece_cnt == 32'd0) open_band();
    last_col  = (col_idx + 32'd1) >= piece_cnt;
    last_band = ({48'd0, band_idx} + 64'd1) >= band_total();
    if (!auto_split_q) begin
      width = {16'd0, piece_w};
      if (last_col && wide_cnt != 16'd0) width = {16'd0, wide_cnt};
    end else begin
      width = {16'd0, piece_w} + ((col_idx < {16'd0, wide_cnt}) ? 32'd1 : 32'd0);
    end
    ypos = {48'd0, band_idx} * bh;
    t.tile_x      = x_pos;
    t.tile_y      = ypos[15:0];
    t.tile_w      = width[15:0];
    t.tile_h      = band_rows;
    t.tile_number = tile_cnt;
    t.last_tile   = last_col && last_band;
    if (t.last_tile) begin
      rewind_walk();
    end else begin
      if (tile_cnt != 32'hFFFF_FFFF) tile_cnt++;
      if (last_col) begin
        col_idx   = '0;
        x_pos     = '0;
        piece_cnt = '0;
        band_idx++;
      end else begin
        col_idx++;
        x_pos = x_pos + width[15:0];
      end
    end
    return t;
  endfunction

  // writes all six registers; only called while the block is idle
  task automatic set_config(input logic [15:0] auto_v, input logic [15:0] w,
                            input logic [15:0] h, input logic [15:0] tw,
                            input logic [15:0] bh, input logic [15:0] f);
    logic [15:0]           vals[6];
    logic [CfgIdxBits-1:0] regs[6];
    vals = '{auto_v, w, h, tw, bh, f};
    regs = '{CfgAutoSplit, CfgImageWidth, CfgImageHeight, CfgTileWidth,
             CfgBandHeight, CfgFrameCount};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      case (regs[i])
        CfgAutoSplit:   auto_split_q = vals[i][0];
        CfgImageWidth:  img_w_q = vals[i];
        CfgImageHeight: img_h_q = vals[i];
        CfgTileWidth:   tile_w_q = vals[i];
        CfgBandHeight:  band_h_q = vals[i];
        CfgFrameCount:  frames_q = vals[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
    configs_applied++;
  endtask

  task automatic send_request(input logic restart);
    int unsigned gap;
    gap = 0;
    if (idle_on) while ($urandom_range(99) < 15) gap++;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (full);
    tiles_due.push_back(next_tile(restart));
    requests_sent++;
  endtask

  task automatic stop_requests();
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tiles_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_dim(input int unsigned small_max);
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(99);
    if (r < 6) return 16'd0;
    if (r < 12) return 16'hFFFF;
    if (r < 18) v = $urandom_range(65535);
    else v = $urandom_range(small_max, 1);
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_frames();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(99);
    if (r < 40) v = $urandom_range(4, 1);
    else if (r < 55) v = 32'hFFFF;
    else if (r < 60) v = 32'd0;
    else v = $urandom_range(65535);
    return v[15:0];
  endfunction

  task automatic test_power_on_defaults();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    stop_requests();
    wait_drained();
  endtask

  // 10x4 image, 4-wide tiles and 3-row bands: remainder column and band
  task automatic test_fixed_grid();
    set_config(16'd0, 16'd10, 16'd4, 16'd4, 16'd3, 16'd1);
    repeat (7) send_request(1'b0);
    send_request(1'b1);
    stop_requests();
    wait_drained();
  endtask

  // full-width image split in two by the pixel budget, one piece wider
  task automatic test_auto_widths();
    set_config(16'd1, 16'hFFFF, 16'd3, 16'd1, 16'd2, 16'd100);
    repeat (3) send_request(1'b0);
    stop_requests();
    wait_drained();
  endtask

  // more pieces than pixels: the last piece comes out zero wide
  task automatic test_over_split();
    set_config(16'd1, 16'd2, 16'd123, 16'd0, 16'd123, 16'hFFFF);
    repeat (3) send_request(1'b0);
    stop_requests();
    wait_drained();
  endtask

  task automatic test_zero_registers();
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(1'b0);
    stop_requests();
    wait_drained();
    set_config(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(1'b0);
    stop_requests();
    wait_drained();
  endtask

  // shrink the image under the next band, then change the tile width mid band
  task automatic test_band_rewrites();
    set_config(16'd0, 16'd8, 16'd8, 16'd4, 16'd2, 16'd1);
    repeat (2) send_request(1'b0);
    stop_requests();
    wait_drained();
    set_config(16'd0, 16'd8, 16'd2, 16'd4, 16'd2, 16'd1);
    send_request(1'b0);
    stop_requests();
    wait_drained();
    set_config(16'd0, 16'd8, 16'd8, 16'd2, 16'd2, 16'd1);
    repeat (2) send_request(1'b0);
    stop_requests();
    wait_drained();
  endtask

  // output held off for a long stretch while requests keep coming
  task automatic test_output_stall();
    idle_on = 1'b0;
    set_config(16'd0, 16'd20, 16'd9, 16'd6, 16'd4, 16'd1);
    hold_off_go <= 1'b1;
    @(posedge clk_i);
    hold_off_go <= 1'b0;
    repeat (40) send_request($urandom_range(15) == 0);
    stop_requests();
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_walks();
    logic [15:0] auto_v;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != RANDOM_PHASES / 2);
      if ($urandom_range(4) == 0) auto_v = $urandom_range(65535);
      else auto_v = $urandom_range(1);
      set_config(auto_v, pick_dim(24), pick_dim(24), pick_dim(24), pick_dim(16),
                 pick_frames());
      repeat (ITEMS_PER_PHASE) send_request($urandom_range(99) < 6);
      stop_requests();
      wait_drained();
    end
    idle_on = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // output side: pops with random idling, checks each tile against the model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        tiles_checked++;
        if (tiles_due.size() == 0) begin
          errors++;
          $display("%0t: tile with nothing expected, expected none, actual x=%0d y=%0d",
                   $time, tile_x_o, tile_y_o);
        end else begin
          tile_want = tiles_due.pop_front();
          compare_field("tile_x", {16'd0, tile_want.tile_x}, {16'd0, tile_x_o});
          compare_field("tile_y", {16'd0, tile_want.tile_y}, {16'd0, tile_y_o});
          compare_field("tile_w", {16'd0, tile_want.tile_w}, {16'd0, tile_w_o});
          compare_field("tile_h", {16'd0, tile_want.tile_h}, {16'd0, tile_h_o});
          compare_field("tile_number", tile_want.tile_number, tile_number_o);
          compare_field("last_tile", {31'd0, tile_want.last_tile}, {31'd0, last_tile_o});
        end
      end
      if (hold_off_go && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(idle_on && $urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_CYCLES) begin
        $display("%0t: watchdog, nothing moved for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("[image_tile_grid_generator] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_on_defaults();
    test_fixed_grid();
    test_auto_widths();
    test_over_split();
    test_zero_registers();
    test_band_rewrites();
    test_output_stall();
    test_random_walks();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d requests, %0d tiles checked, %0d register settings",
             requests_sent, tiles_checked, configs_applied);
    $display("fixed and auto split, zero and full-scale registers, restarts, output stall");
    if (errors == 0) $display("[image_tile_grid_generator] OK");
    else $display("[image_tile_grid_generator] ERROR");
    $finish;
  end

endmodule
